// File: sv/iiex_pkg.sv
// Package with the request and response types, operation codes and sizes of the execute unit.
`timescale 1ns / 1ps

package iiex_pkg;

	// Sizes of the architectural state.
	localparam int unsigned MEM_BYTES = 65536;
	localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
	localparam logic [31:0] STACK_TOP = 32'd65536;

	// Fixed register numbers.
	localparam logic [4:0] ZERO_REG     = 5'd0;
	localparam logic [4:0] SYS_CODE_REG = 5'd2;
	localparam logic [4:0] SYS_ARG_REG  = 5'd4;
	localparam logic [4:0] STACK_REG    = 5'd29;
	localparam logic [4:0] LINK_REG     = 5'd31;

	// Error codes.
	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN = 2'd1;
	localparam logic [1:0] ERR_DIVZERO = 2'd2;

	// Operation codes.
	localparam logic [5:0] OP_ADD     = 6'd0;
	localparam logic [5:0] OP_ADDU    = 6'd1;
	localparam logic [5:0] OP_ADDIU   = 6'd2;
	localparam logic [5:0] OP_SUB     = 6'd3;
	localparam logic [5:0] OP_SUBU    = 6'd4;
	localparam logic [5:0] OP_MUL     = 6'd5;
	localparam logic [5:0] OP_MULU    = 6'd6;
	localparam logic [5:0] OP_DIV     = 6'd7;
	localparam logic [5:0] OP_DIVU    = 6'd8;
	localparam logic [5:0] OP_XOR     = 6'd9;
	localparam logic [5:0] OP_XORU    = 6'd10;
	localparam logic [5:0] OP_NEG     = 6'd11;
	localparam logic [5:0] OP_NEGU    = 6'd12;
	localparam logic [5:0] OP_REM     = 6'd13;
	localparam logic [5:0] OP_REMU    = 6'd14;
	localparam logic [5:0] OP_LI      = 6'd15;
	localparam logic [5:0] OP_SEQ     = 6'd16;
	localparam logic [5:0] OP_SGE     = 6'd17;
	localparam logic [5:0] OP_SGT     = 6'd18;
	localparam logic [5:0] OP_SLE     = 6'd19;
	localparam logic [5:0] OP_SLT     = 6'd20;
	localparam logic [5:0] OP_SNE     = 6'd21;
	localparam logic [5:0] OP_B       = 6'd22;
	localparam logic [5:0] OP_BEQ     = 6'd23;
	localparam logic [5:0] OP_BNE     = 6'd24;
	localparam logic [5:0] OP_BGE     = 6'd25;
	localparam logic [5:0] OP_BLE     = 6'd26;
	localparam logic [5:0] OP_BGT     = 6'd27;
	localparam logic [5:0] OP_BLT     = 6'd28;
	localparam logic [5:0] OP_BEQZ    = 6'd29;
	localparam logic [5:0] OP_BNEZ    = 6'd30;
	localparam logic [5:0] OP_BGEZ    = 6'd31;
	localparam logic [5:0] OP_BLEZ    = 6'd32;
	localparam logic [5:0] OP_BGTZ    = 6'd33;
	localparam logic [5:0] OP_BLTZ    = 6'd34;
	localparam logic [5:0] OP_J       = 6'd35;
	localparam logic [5:0] OP_JR      = 6'd36;
	localparam logic [5:0] OP_JAL     = 6'd37;
	localparam logic [5:0] OP_JALR    = 6'd38;
	localparam logic [5:0] OP_MOVE    = 6'd39;
	localparam logic [5:0] OP_MFHI    = 6'd40;
	localparam logic [5:0] OP_MFLO    = 6'd41;
	localparam logic [5:0] OP_LA      = 6'd42;
	localparam logic [5:0] OP_LB      = 6'd43;
	localparam logic [5:0] OP_LH      = 6'd44;
	localparam logic [5:0] OP_LW      = 6'd45;
	localparam logic [5:0] OP_SB      = 6'd46;
	localparam logic [5:0] OP_SH      = 6'd47;
	localparam logic [5:0] OP_SW      = 6'd48;
	localparam logic [5:0] OP_NOP     = 6'd49;
	localparam logic [5:0] OP_SYSCALL = 6'd50;

	// One pre-decoded instruction.
	typedef struct packed {
		logic [5:0]         action;
		logic [4:0]         dest_reg;
		logic [4:0]         src_a_reg;
		logic [4:0]         src_b_reg;
		logic               use_imm;
		logic signed [31:0] imm_value;
		logic               use_abs_addr;
		logic [31:0]        abs_addr;
		logic signed [31:0] addr_offset;
		logic               to_hilo;
		logic [30:0]        instr_index;
	} cmd_t;

	// Outcome of one instruction.
	typedef struct packed {
		logic               jump_taken;
		logic [31:0]        jump_target;
		logic               syscall_request;
		logic signed [31:0] syscall_code;
		logic signed [31:0] syscall_arg;
		logic [1:0]         error_code;
	} rsp_t;

	// Operands handed to the divider.
	typedef struct packed {
		logic [31:0] dividend;
		logic [31:0] divisor;
		logic        is_signed;
	} div_req_t;

	// Quotient and remainder from the divider.
	typedef struct packed {
		logic [31:0] quotient;
		logic [31:0] remainder;
	} div_rsp_t;

endpackage

// File: sv/iiex_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed or unsigned.
`timescale 1ns / 1ps

module iiex_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  iiex_pkg::div_req_t req,
	output logic               done,
	output iiex_pkg::div_rsp_t rsp
);
	import iiex_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        qneg_q;
	logic        rneg_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic [31:0] mag_a;
	logic [31:0] mag_b;

	// Magnitudes of the operands for signed division.
	assign mag_a = (req.is_signed && req.dividend[31]) ? (32'd0 - req.dividend) : req.dividend;
	assign mag_b = (req.is_signed && req.divisor[31]) ? (32'd0 - req.divisor) : req.divisor;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath of the iteration.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= mag_a;
			dvs_q  <= mag_b;
			qneg_q <= req.is_signed && (req.dividend[31] ^ req.divisor[31]);
			rneg_q <= req.is_signed && req.dividend[31];
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// Signs are restored on the way out; quotient truncates toward zero.
	assign done          = done_q;
	assign rsp.quotient  = qneg_q ? (32'd0 - quo_q) : quo_q;
	assign rsp.remainder = rneg_q ? (32'd0 - rem_q) : rem_q;

endmodule

// File: sv/integer_isa_execute_unit.sv
// Top level of the integer execute unit: sequencer, register file, data memory, multiplier and divider.
`timescale 1ns / 1ps

// Executes one pre-decoded integer instruction per request against a 32-word register
// file, hi/lo and a byte-wide little-endian data memory, returning one response per
// request. After reset the unit clears the data memory, one byte a cycle, before it
// takes its first request. Instructions are executed one at a time by a sequencer
// around the single-write, two-read register file: acceptance, two register read
// steps (RD1, RD2) and an execute step (EXEC), then a step (FIN) that hands the
// response to the output register. Multiplies add a step for the registered product
// (MUL), divides and remainders wait on the 32-step divider (DIV), loads pass through
// LDA and LDB for each byte and stores through ST for each byte on the single data
// memory port (lb/sb 1 byte, lh/sh 2, lw/sw 4). A new request is taken while an
// earlier response still waits on the output.
module integer_isa_execute_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  iiex_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output iiex_pkg::rsp_t rsp
);
	import iiex_pkg::*;

	typedef enum logic [10:0] {
		S_CLR  = 11'b00000000001,
		S_IDLE = 11'b00000000010,
		S_RD1  = 11'b00000000100,
		S_RD2  = 11'b00000001000,
		S_EXEC = 11'b00000010000,
		S_MUL  = 11'b00000100000,
		S_DIV  = 11'b00001000000,
		S_LDA  = 11'b00010000000,
		S_LDB  = 11'b00100000000,
		S_ST   = 11'b01000000000,
		S_FIN  = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	cmd_t        req_q;
	rsp_t        res_q;
	rsp_t        out_q;
	logic        out_valid_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] d_q;
	logic [31:0] ad_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [63:0] prod_s1;
	logic [1:0]  kcnt_q;
	logic [31:0] ld_q;
	logic [MEM_AW-1:0] clr_q;

	// Register file storage with valid bits standing in for the reset values.
	logic [31:0] rf [32];
	logic [31:0] rf_vld_q;
	logic [4:0]  ra0;
	logic [4:0]  ra1;
	logic [4:0]  ra0_q;
	logic [4:0]  ra1_q;
	logic [31:0] rd0_q;
	logic [31:0] rd1_q;
	logic [31:0] rv0;
	logic [31:0] rv1;
	logic        wr_en;
	logic [4:0]  wr_addr;
	logic [31:0] wr_data;

	// Data memory.
	logic [7:0]        dm [MEM_BYTES];
	logic [MEM_AW-1:0] dm_addr;
	logic              dm_we;
	logic [7:0]        dm_wdata;
	logic [7:0]        dm_rd_q;
	logic [31:0]       byte_addr;

	// Execute-stage values.
	logic [5:0]  op;
	logic [31:0] ad_c;
	logic [31:0] link;
	logic        lt_ab;
	logic        lt_ba;
	logic        taken;
	logic [31:0] target;
	logic [1:0]  err;
	logic        is_sys;
	logic        hilo_we;
	logic [31:0] hi_d;
	logic [31:0] lo_d;
	logic        div_start;
	logic        div_done;
	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic [1:0]  klast;
	logic [31:0] ld_next;
	logic [63:0] prod_c;
	logic        mul_signed;

	// Reads of entries never written return their reset value.
	function automatic logic [31:0] rf_value(input logic [4:0] addr, input logic [31:0] data,
			input logic vld);
		logic [31:0] v;
		if (addr == ZERO_REG) begin
			v = '0;
		end else if (vld) begin
			v = data;
		end else if (addr == STACK_REG) begin
			v = STACK_TOP;
		end else begin
			v = '0;
		end
		return v;
	endfunction

	assign op     = req_q.action;
	assign is_sys = (op == OP_SYSCALL);
	assign rv0    = rf_value(ra0_q, rd0_q, rf_vld_q[ra0_q]);
	assign rv1    = rf_value(ra1_q, rd1_q, rf_vld_q[ra1_q]);
	assign ad_c   = req_q.use_abs_addr ? req_q.abs_addr : (a_q + req_q.addr_offset);
	assign link   = {1'b0, req_q.instr_index} + 32'd1;
	assign lt_ab  = $signed(a_q) < $signed(b_q);
	assign lt_ba  = $signed(b_q) < $signed(a_q);

	// Read address selection: sources first, then the destination register.
	always_comb begin
		if (state_q == S_RD1) begin
			ra0 = is_sys ? SYS_CODE_REG : req_q.src_a_reg;
			ra1 = is_sys ? SYS_ARG_REG : req_q.src_b_reg;
		end else begin
			ra0 = req_q.dest_reg;
			ra1 = req_q.src_b_reg;
		end
	end

	// Register file ports.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr != ZERO_REG)) begin
			rf[wr_addr] <= wr_data;
		end
		rd0_q <= rf[ra0];
		rd1_q <= rf[ra1];
		ra0_q <= ra0;
		ra1_q <= ra1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wr_en && (wr_addr != ZERO_REG)) begin
			rf_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Data memory port: clearing pass after reset, then byte accesses.
	assign byte_addr = ad_q + {30'd0, kcnt_q};
	assign dm_addr   = (state_q == S_CLR) ? clr_q : byte_addr[MEM_AW-1:0];

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dm[dm_addr] <= dm_wdata;
		end
		dm_rd_q <= dm[dm_addr];
	end

	// Full product, signed or unsigned.
	assign mul_signed = (op == OP_MUL);
	assign prod_c = 64'($signed({mul_signed & a_q[31], a_q}) *
		$signed({mul_signed & b_q[31], b_q}));

	// Divider operands.
	assign div_req.dividend  = a_q;
	assign div_req.divisor   = b_q;
	assign div_req.is_signed = (op == OP_DIV) || (op == OP_REM);

	iiex_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done   (div_done),
		.rsp    (div_rsp)
	);

	// Last byte index of a memory access and the load value gathered so far.
	always_comb begin
		case (op)
			OP_LB, OP_SB: klast = 2'd0;
			OP_LH, OP_SH: klast = 2'd1;
			default:      klast = 2'd3;
		endcase
		case (kcnt_q)
			2'd0:    ld_next = ld_q | {24'd0, dm_rd_q};
			2'd1:    ld_next = ld_q | {16'd0, dm_rd_q, 8'd0};
			2'd2:    ld_next = ld_q | {8'd0, dm_rd_q, 16'd0};
			default: ld_next = ld_q | {dm_rd_q, 24'd0};
		endcase
	end

	// Sequencer: next state, register writes and execute results.
	always_comb begin
		state_d   = state_q;
		wr_en     = 1'b0;
		wr_addr   = req_q.dest_reg;
		wr_data   = '0;
		hilo_we   = 1'b0;
		hi_d      = hi_q;
		lo_d      = lo_q;
		div_start = 1'b0;
		dm_we     = 1'b0;
		dm_wdata  = '0;
		taken     = 1'b0;
		target    = ad_c;
		err       = ERR_OK;
		case (state_q)
			S_CLR: begin
				dm_we = 1'b1;
				if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_RD1;
				end
			end
			S_RD1: state_d = S_RD2;
			S_RD2: state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_FIN;
				case (op)
					OP_ADD, OP_ADDU, OP_ADDIU: begin
						wr_en = 1'b1; wr_data = a_q + b_q;
					end
					OP_SUB, OP_SUBU: begin
						wr_en = 1'b1; wr_data = a_q - b_q;
					end
					OP_MUL, OP_MULU: state_d = S_MUL;
					OP_DIV, OP_DIVU, OP_REM, OP_REMU: begin
						if (b_q == 32'd0) begin
							err = ERR_DIVZERO;
						end else begin
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
					OP_XOR, OP_XORU: begin
						wr_en = 1'b1; wr_data = a_q ^ b_q;
					end
					OP_NEG, OP_NEGU: begin
						wr_en = 1'b1; wr_data = 32'd0 - a_q;
					end
					OP_LI: begin
						wr_en = 1'b1; wr_data = req_q.imm_value;
					end
					OP_SEQ: begin wr_en = 1'b1; wr_data = {31'd0, a_q == b_q}; end
					OP_SGE: begin wr_en = 1'b1; wr_data = {31'd0, !lt_ab}; end
					OP_SGT: begin wr_en = 1'b1; wr_data = {31'd0, lt_ba}; end
					OP_SLE: begin wr_en = 1'b1; wr_data = {31'd0, !lt_ba}; end
					OP_SLT: begin wr_en = 1'b1; wr_data = {31'd0, lt_ab}; end
					OP_SNE: begin wr_en = 1'b1; wr_data = {31'd0, a_q != b_q}; end
					OP_B, OP_J: taken = 1'b1;
					OP_BEQ:  taken = (a_q == b_q);
					OP_BNE:  taken = (a_q != b_q);
					OP_BGE:  taken = !lt_ab;
					OP_BLE:  taken = !lt_ba;
					OP_BGT:  taken = lt_ba;
					OP_BLT:  taken = lt_ab;
					OP_BEQZ: taken = (a_q == 32'd0);
					OP_BNEZ: taken = (a_q != 32'd0);
					OP_BGEZ: taken = !a_q[31];
					OP_BLEZ: taken = a_q[31] || (a_q == 32'd0);
					OP_BGTZ: taken = !a_q[31] && (a_q != 32'd0);
					OP_BLTZ: taken = a_q[31];
					OP_JR: begin
						taken = 1'b1; target = rv0;
					end
					OP_JAL: begin
						taken = 1'b1; wr_en = 1'b1; wr_addr = LINK_REG; wr_data = link;
					end
					OP_JALR: begin
						taken   = 1'b1;
						target  = rv0;
						wr_en   = 1'b1;
						wr_addr = LINK_REG;
						wr_data = link;
					end
					OP_MOVE: begin wr_en = 1'b1; wr_data = a_q; end
					OP_MFHI: begin wr_en = 1'b1; wr_data = hi_q; end
					OP_MFLO: begin wr_en = 1'b1; wr_data = lo_q; end
					OP_LA:   begin wr_en = 1'b1; wr_data = ad_c; end
					OP_LB, OP_LH, OP_LW: state_d = S_LDA;
					OP_SB, OP_SH, OP_SW: state_d = S_ST;
					OP_NOP, OP_SYSCALL: state_d = S_FIN;
					default: err = ERR_UNKNOWN;
				endcase
			end
			S_MUL: begin
				state_d = S_FIN;
				if (req_q.to_hilo) begin
					hilo_we = 1'b1;
					hi_d    = prod_s1[63:32];
					lo_d    = prod_s1[31:0];
				end else begin
					wr_en   = 1'b1;
					wr_data = prod_s1[31:0];
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_FIN;
					if ((op == OP_REM) || (op == OP_REMU)) begin
						wr_en   = 1'b1;
						wr_data = div_rsp.remainder;
					end else if (req_q.to_hilo) begin
						hilo_we = 1'b1;
						hi_d    = div_rsp.remainder;
						lo_d    = div_rsp.quotient;
					end else begin
						wr_en   = 1'b1;
						wr_data = div_rsp.quotient;
					end
				end
			end
			S_LDA: state_d = S_LDB;
			S_LDB: begin
				if (kcnt_q == klast) begin
					state_d = S_FIN;
					wr_en   = 1'b1;
					case (op)
						OP_LB:   wr_data = {{24{ld_next[7]}}, ld_next[7:0]};
						OP_LH:   wr_data = {{16{ld_next[15]}}, ld_next[15:0]};
						default: wr_data = ld_next;
					endcase
				end else begin
					state_d = S_LDA;
				end
			end
			S_ST: begin
				dm_we = 1'b1;
				case (kcnt_q)
					2'd0:    dm_wdata = d_q[7:0];
					2'd1:    dm_wdata = d_q[15:8];
					2'd2:    dm_wdata = d_q[23:16];
					default: dm_wdata = d_q[31:24];
				endcase
				if (kcnt_q == klast) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			hi_q        <= '0;
			lo_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + MEM_AW'(1);
			end
			if (hilo_we) begin
				hi_q <= hi_d;
				lo_q <= lo_d;
			end
			if ((state_q == S_FIN) && (!out_valid_q || !rsp_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= cmd;
			end
			S_RD2: begin
				a_q <= rv0;
				b_q <= (req_q.use_imm && !is_sys) ? req_q.imm_value : rv1;
			end
			S_EXEC: begin
				d_q     <= rv0;
				ad_q    <= ad_c;
				kcnt_q  <= '0;
				ld_q    <= '0;
				prod_s1 <= prod_c;
				res_q.jump_taken      <= taken;
				res_q.jump_target     <= taken ? target : 32'd0;
				res_q.syscall_request <= is_sys;
				res_q.syscall_code    <= is_sys ? a_q : 32'd0;
				res_q.syscall_arg     <= is_sys ? b_q : 32'd0;
				res_q.error_code      <= err;
			end
			S_LDB: begin
				ld_q   <= ld_next;
				kcnt_q <= kcnt_q + 2'd1;
			end
			S_ST: begin
				kcnt_q <= kcnt_q + 2'd1;
			end
			S_FIN: begin
				if (!out_valid_q || !rsp_stall) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: sim/integer_isa_execute_unit_tb.sv
// Self-checking testbench for the integer execute unit with a built-in instruction predictor.
`timescale 1ns / 1ps

module integer_isa_execute_unit_tb;
	import iiex_pkg::*;

	localparam int STALL_LIMIT = 200000;
	localparam int QUIET_TAIL  = 250;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	integer_isa_execute_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Predictor state: a shadow of the architectural state of the unit.
	logic [31:0] shadow_regs [32];
	logic [31:0] shadow_hi;
	logic [31:0] shadow_lo;
	logic [7:0]  shadow_mem [MEM_BYTES];

	cmd_t pending_cmds [$];
	rsp_t expected_rsps [$];
	int   mismatch_count;
	int   idle_cycles;
	logic stim_done;
	logic quiet_phase;
	logic hold_for_drain;
	int   tx_gap;
	int   rx_gap;

	function automatic logic [31:0] read_reg(logic [4:0] idx);
		return (idx == ZERO_REG) ? 32'd0 : shadow_regs[idx];
	endfunction

	function automatic void write_reg(logic [4:0] idx, logic [31:0] v);
		if (idx != ZERO_REG)
			shadow_regs[idx] = v;
	endfunction

	function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic [31:0] mem_load(logic [31:0] addr, int n);
		logic [31:0] v;
		logic [31:0] ea;
		v = 0;
		for (int k = 0; k < n; k++) begin
			ea = addr + k;
			v[8*k +: 8] = shadow_mem[ea % MEM_BYTES];
		end
		return v;
	endfunction

	function automatic void mem_store(logic [31:0] addr, int n, logic [31:0] v);
		logic [31:0] ea;
		for (int k = 0; k < n; k++) begin
			ea = addr + k;
			shadow_mem[ea % MEM_BYTES] = v[8*k +: 8];
		end
	endfunction

	// Executes one instruction on the shadow state and returns its outcome.
	function automatic rsp_t execute_instr(cmd_t c);
		rsp_t r;
		logic [31:0] a, b, ad, q, rm, t, link;
		logic [63:0] p;
		logic taken;
		r = '0;
		taken = 1'b0;
		a = read_reg(c.src_a_reg);
		b = c.use_imm ? c.imm_value : read_reg(c.src_b_reg);
		ad = c.use_abs_addr ? c.abs_addr : a + c.addr_offset;
		link = {1'b0, c.instr_index} + 32'd1;
		case (c.action)
			OP_ADD, OP_ADDU, OP_ADDIU: write_reg(c.dest_reg, a + b);
			OP_SUB, OP_SUBU: write_reg(c.dest_reg, a - b);
			OP_MUL, OP_MULU: begin
				if (c.action == OP_MUL)
					p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				else
					p = {32'd0, a} * {32'd0, b};
				if (c.to_hilo) begin
					shadow_hi = p[63:32];
					shadow_lo = p[31:0];
				end else
					write_reg(c.dest_reg, p[31:0]);
			end
			OP_DIV, OP_DIVU, OP_REM, OP_REMU: begin
				if (b == 0)
					r.error_code = ERR_DIVZERO;
				else begin
					if (c.action == OP_DIVU || c.action == OP_REMU) begin
						q = a / b;
						rm = a % b;
					end else if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
						q = 32'h8000_0000;
						rm = 0;
					end else begin
						q = $signed(a) / $signed(b);
						rm = $signed(a) % $signed(b);
					end
					if (c.action == OP_REM || c.action == OP_REMU)
						write_reg(c.dest_reg, rm);
					else if (c.to_hilo) begin
						shadow_lo = q;
						shadow_hi = rm;
					end else
						write_reg(c.dest_reg, q);
				end
			end
			OP_XOR, OP_XORU: write_reg(c.dest_reg, a ^ b);
			OP_NEG, OP_NEGU: write_reg(c.dest_reg, 32'd0 - a);
			OP_LI:  write_reg(c.dest_reg, c.imm_value);
			OP_SEQ: write_reg(c.dest_reg, {31'd0, a == b});
			OP_SGE: write_reg(c.dest_reg, {31'd0, !signed_lt(a, b)});
			OP_SGT: write_reg(c.dest_reg, {31'd0, signed_lt(b, a)});
			OP_SLE: write_reg(c.dest_reg, {31'd0, !signed_lt(b, a)});
			OP_SLT: write_reg(c.dest_reg, {31'd0, signed_lt(a, b)});
			OP_SNE: write_reg(c.dest_reg, {31'd0, a != b});
			OP_B, OP_J: taken = 1'b1;
			OP_BEQ:  taken = (a == b);
			OP_BNE:  taken = (a != b);
			OP_BGE:  taken = !signed_lt(a, b);
			OP_BLE:  taken = !signed_lt(b, a);
			OP_BGT:  taken = signed_lt(b, a);
			OP_BLT:  taken = signed_lt(a, b);
			OP_BEQZ: taken = (a == 0);
			OP_BNEZ: taken = (a != 0);
			OP_BGEZ: taken = !a[31];
			OP_BLEZ: taken = a[31] || a == 0;
			OP_BGTZ: taken = !a[31] && a != 0;
			OP_BLTZ: taken = a[31];
			OP_JR: begin
				taken = 1'b1;
				ad = read_reg(c.dest_reg);
			end
			OP_JAL: begin
				taken = 1'b1;
				write_reg(LINK_REG, link);
			end
			OP_JALR: begin
				taken = 1'b1;
				ad = read_reg(c.dest_reg);
				write_reg(LINK_REG, link);
			end
			OP_MOVE: write_reg(c.dest_reg, a);
			OP_MFHI: write_reg(c.dest_reg, shadow_hi);
			OP_MFLO: write_reg(c.dest_reg, shadow_lo);
			OP_LA:   write_reg(c.dest_reg, ad);
			OP_LB: begin
				t = mem_load(ad, 1);
				write_reg(c.dest_reg, {{24{t[7]}}, t[7:0]});
			end
			OP_LH: begin
				t = mem_load(ad, 2);
				write_reg(c.dest_reg, {{16{t[15]}}, t[15:0]});
			end
			OP_LW: write_reg(c.dest_reg, mem_load(ad, 4));
			OP_SB: mem_store(ad, 1, read_reg(c.dest_reg));
			OP_SH: mem_store(ad, 2, read_reg(c.dest_reg));
			OP_SW: mem_store(ad, 4, read_reg(c.dest_reg));
			OP_NOP: ;
			OP_SYSCALL: begin
				r.syscall_request = 1'b1;
				r.syscall_code = read_reg(SYS_CODE_REG);
				r.syscall_arg = read_reg(SYS_ARG_REG);
			end
			default: r.error_code = ERR_UNKNOWN;
		endcase
		r.jump_taken = taken;
		r.jump_target = taken ? ad : 32'd0;
		return r;
	endfunction

	// Random instruction with random fields everywhere.
	function automatic cmd_t random_instr();
		cmd_t c;
		c.action = 6'($urandom_range(0, 63));
		c.dest_reg = 5'($urandom_range(0, 31));
		c.src_a_reg = 5'($urandom_range(0, 31));
		c.src_b_reg = 5'($urandom_range(0, 31));
		c.use_imm = 1'($urandom_range(0, 1));
		c.imm_value = $urandom;
		c.use_abs_addr = 1'($urandom_range(0, 1));
		c.abs_addr = $urandom;
		c.addr_offset = $urandom;
		c.to_hilo = 1'($urandom_range(0, 1));
		c.instr_index = 31'($urandom);
		return c;
	endfunction

	// Biases an instruction toward interesting operands and valid operations.
	function automatic cmd_t shaped_instr();
		cmd_t c;
		c = random_instr();
		if ($urandom_range(0, 9) != 0)
			c.action = 6'($urandom_range(0, OP_SYSCALL));
		case ($urandom_range(0, 5))
			0: c.imm_value = 0;
			1: c.imm_value = 32'hffff_ffff;
			2: c.imm_value = 32'h8000_0000;
			3: c.imm_value = $urandom_range(0, 255);
			default: ;
		endcase
		// Keep most addresses inside a small window so that loads see stores.
		if ($urandom_range(0, 3) != 0) begin
			c.abs_addr = $urandom_range(0, 63) + (($urandom_range(0, 3) == 0) ? 32'hffff_ffe0 : 0);
			c.addr_offset = $signed($urandom_range(0, 64)) - 32;
		end
		if ($urandom_range(0, 3) == 0)
			c.src_a_reg = STACK_REG;
		return c;
	endfunction

	function automatic cmd_t make_instr(logic [5:0] op, logic [4:0] rd, logic [4:0] rs,
			logic [4:0] rt, logic imm_sel, logic [31:0] imm);
		cmd_t c;
		c = '0;
		c.action = op;
		c.dest_reg = rd;
		c.src_a_reg = rs;
		c.src_b_reg = rt;
		c.use_imm = imm_sel;
		c.imm_value = imm;
		c.abs_addr = 32'd16;
		c.addr_offset = -4;
		c.instr_index = 31'h7fff_ffff;
		return c;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus: directed instructions, then random ones.
	initial begin
		cmd_t c;
		for (int i = 0; i < 32; i++)
			shadow_regs[i] = 0;
		shadow_regs[STACK_REG] = STACK_TOP;
		shadow_hi = 0;
		shadow_lo = 0;
		for (int i = 0; i < MEM_BYTES; i++)
			shadow_mem[i] = 0;
		stim_done = 1'b0;
		quiet_phase = 1'b0;
		hold_for_drain = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Corner operands: extremes, signed overflow divide and divide by zero.
		pending_cmds.push_back(make_instr(OP_LI, 5'd1, 0, 0, 0, 32'h8000_0000));
		pending_cmds.push_back(make_instr(OP_LI, 5'd2, 0, 0, 0, 32'hffff_ffff));
		pending_cmds.push_back(make_instr(OP_LI, 5'd4, 0, 0, 0, 32'h7fff_ffff));
		pending_cmds.push_back(make_instr(OP_DIV, 5'd3, 5'd1, 5'd2, 0, 0));
		pending_cmds.push_back(make_instr(OP_REM, 5'd3, 5'd1, 5'd2, 0, 0));
		c = make_instr(OP_DIV, 5'd3, 5'd1, 5'd2, 0, 0);
		c.to_hilo = 1'b1;
		pending_cmds.push_back(c);
		pending_cmds.push_back(make_instr(OP_DIVU, 5'd3, 5'd1, 5'd0, 0, 0));
		pending_cmds.push_back(make_instr(OP_REMU, 5'd3, 5'd1, 5'd0, 1, 0));
		c = make_instr(OP_MUL, 5'd3, 5'd1, 5'd2, 0, 0);
		c.to_hilo = 1'b1;
		pending_cmds.push_back(c);
		pending_cmds.push_back(make_instr(OP_MFHI, 5'd5, 0, 0, 0, 0));
		pending_cmds.push_back(make_instr(OP_MFLO, 5'd6, 0, 0, 0, 0));
		pending_cmds.push_back(make_instr(OP_LI, 5'd0, 0, 0, 0, 32'h1234_5678));
		pending_cmds.push_back(make_instr(OP_ADD, 5'd7, 5'd4, 5'd0, 1, 32'd1));
		pending_cmds.push_back(make_instr(OP_SUBU, 5'd8, 5'd0, 5'd4, 0, 0));
		pending_cmds.push_back(make_instr(OP_SW, 5'd1, 5'd29, 0, 0, 0));
		pending_cmds.push_back(make_instr(OP_LB, 5'd9, 5'd29, 0, 0, 0));
		c = make_instr(OP_LH, 5'd10, 0, 0, 0, 0);
		c.use_abs_addr = 1'b1;
		c.abs_addr = 32'hffff_fffe;
		pending_cmds.push_back(c);
		pending_cmds.push_back(make_instr(OP_JALR, 5'd4, 0, 0, 0, 0));
		pending_cmds.push_back(make_instr(OP_JAL, 5'd0, 0, 0, 0, 0));
		pending_cmds.push_back(make_instr(OP_BLTZ, 5'd0, 5'd1, 0, 0, 0));
		pending_cmds.push_back(make_instr(OP_SLT, 5'd11, 5'd1, 5'd4, 0, 0));
		pending_cmds.push_back(make_instr(OP_SYSCALL, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_instr(6'd63, 5'd1, 0, 0, 0, 0));
		// Every operation once with random content.
		for (int op = 0; op <= OP_SYSCALL; op++) begin
			c = shaped_instr();
			c.action = 6'(op);
			pending_cmds.push_back(c);
		end
		wait (pending_cmds.size() == 0);

		// Pause until all responses are back, then continue.
		hold_for_drain = 1'b1;
		wait (expected_rsps.size() == 0);
		hold_for_drain = 1'b0;

		for (int i = 0; i < 1200; i++) begin
			c = ($urandom_range(0, 7) == 0) ? random_instr() : shaped_instr();
			pending_cmds.push_back(c);
			if (i == 1000)
				quiet_phase = 1'b1;
			while (pending_cmds.size() > 8)
				@(posedge clk);
		end
		wait (pending_cmds.size() == 0);
		stim_done = 1'b1;
	end

	// Driver: presents queued requests with random gaps outside the quiet phase; the
	// request on the bus stays at the head of the queue until it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			tx_gap <= 0;
		end else if (!(cmd_valid && cmd_stall)) begin
			if (cmd_valid) begin
				expected_rsps.push_back(execute_instr(cmd));
				void'(pending_cmds.pop_front());
			end
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				cmd_valid <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				tx_gap <= $urandom_range(0, 2);
				cmd_valid <= 1'b0;
			end else if (hold_for_drain || pending_cmds.size() == 0) begin
				cmd_valid <= 1'b0;
			end else begin
				cmd_valid <= 1'b1;
				cmd <= pending_cmds[0];
			end
		end
	end

	// Monitor: stalls at random outside the quiet phase and checks each accepted response.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rx_gap <= 0;
			mismatch_count <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("ERROR: unexpected response %h", rsp);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp !== want) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display("ERROR: exp/act tk %b/%b tgt %h/%h sys %b/%b %h/%h %h/%h e %0d/%0d",
								want.jump_taken, rsp.jump_taken, want.jump_target, rsp.jump_target,
								want.syscall_request, rsp.syscall_request,
								want.syscall_code, rsp.syscall_code,
								want.syscall_arg, rsp.syscall_arg,
								want.error_code, rsp.error_code);
					end
				end
			end
			if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				rsp_stall <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				rx_gap <= $urandom_range(0, 2);
				rsp_stall <= 1'b1;
			end else
				rsp_stall <= 1'b0;
		end
	end

	// Watchdog and end of run.
	initial begin
		int tail;
		idle_cycles = 0;
		tail = 0;
		forever begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
			if (stim_done && !cmd_valid && expected_rsps.size() == 0)
				tail = tail + 1;
			if (tail >= QUIET_TAIL) begin
				if (mismatch_count == 0 && expected_rsps.size() == 0)
					$display("TEST PASSED");
				else
					$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule

// File: filelist.f
sv/iiex_pkg.sv
sv/iiex_div.sv
sv/integer_isa_execute_unit.sv
sim/integer_isa_execute_unit_tb.sv
